// File: hdl/urc_pkg.sv
// ----------------------------------------------------------------------------
// urc_pkg
// Shared types, constants and state codes for the UART transmit ring with
// line feed to CR/LF expansion.
// ----------------------------------------------------------------------------
package urc_pkg;

   // default sizes
   localparam int RING_DEPTH_DEF      = 256;
   localparam int UART_FIFO_DEPTH_DEF = 32;

   // most results one request may cause
   localparam int RESULT_LIMIT = 32;
   localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

   // characters
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   // request functions
   localparam logic FUNC_PUSH  = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
      logic [5:0] fifo_room;
   } urc_req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
      logic       forced;
      logic [7:0] ring_fill;
   } urc_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FULL_CHK,
      ST_FULL_RD,
      ST_WRITE,
      ST_SEND_CHK,
      ST_DRAIN,
      ST_FINISH,
      ST_FLUSH
   } urc_state_type;

   // which pointer the shared step unit advances
   typedef enum logic {
      SEL_WP,
      SEL_RP
   } urc_ptr_sel_type;

   // sequencer to result stage
   typedef struct packed {
      logic rd_fire;
      logic rd_forced;
      logic flush;
   } urc_ctl_type;

endpackage

// File: hdl/urc_ring_mem.sv
// ----------------------------------------------------------------------------
// urc_ring_mem
// Ring byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module urc_ring_mem #(
   parameter int DEPTH = urc_pkg::RING_DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   // store the byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // fetch the oldest byte
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/urc_ptr_unit.sv
// ----------------------------------------------------------------------------
// urc_ptr_unit
// Shared pointer step unit: advances the selected pointer with wrap, and
// compares the pointers for full, empty and fill level.
// ----------------------------------------------------------------------------
module urc_ptr_unit #(
   parameter int RING_DEPTH = urc_pkg::RING_DEPTH_DEF,
   parameter int PW         = $clog2(RING_DEPTH)
) (
   input  logic [PW-1:0]             wp,
   input  logic [PW-1:0]             rp,
   input  urc_pkg::urc_ptr_sel_type  sel,
   output logic [PW-1:0]             nxt,
   output logic                      full,
   output logic                      empty,
   output logic [7:0]                fill
);

   import urc_pkg::*;

   logic [PW-1:0] src;
   logic [PW-1:0] level;

   // advance the selected pointer, wrapping at the ring depth
   assign src = (sel == SEL_WP) ? wp : rp;
   assign nxt = (src == PW'(RING_DEPTH - 1)) ? '0 : src + 1'b1;

   // full when the advanced write pointer meets the read pointer
   assign full  = (nxt == rp);
   assign empty = (wp == rp);

   // bytes held, modulo the ring depth
   always_comb begin
      if (wp >= rp) begin
         level = wp - rp;
      end else begin
         level = PW'(RING_DEPTH) - rp + wp;
      end
   end

   assign fill = 8'(level);

endmodule

// File: hdl/urc_seq.sv
// ----------------------------------------------------------------------------
// urc_seq
// Request sequencer: owns the ring pointers and the FIFO room count, and
// steps through store and send operations one at a time.
// ----------------------------------------------------------------------------
module urc_seq #(
   parameter int RING_DEPTH      = urc_pkg::RING_DEPTH_DEF,
   parameter int UART_FIFO_DEPTH = urc_pkg::UART_FIFO_DEPTH_DEF,
   parameter int PW              = $clog2(RING_DEPTH)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  urc_pkg::urc_req_type     req_data,
   // pointer unit
   output logic [PW-1:0]            wp,
   output logic [PW-1:0]            rp,
   output urc_pkg::urc_ptr_sel_type ptr_sel,
   input  logic [PW-1:0]            ptr_nxt,
   input  logic                     ptr_full,
   input  logic                     ptr_empty,
   // ring store
   output logic                     mem_wr_en,
   output logic [PW-1:0]            mem_wr_addr,
   output logic [7:0]               mem_wr_data,
   output logic                     mem_rd_en,
   output logic [PW-1:0]            mem_rd_addr,
   // result stage
   output urc_pkg::urc_ctl_type     ctl
);

   import urc_pkg::*;

   localparam int RW = $clog2(UART_FIFO_DEPTH + 1);

   urc_state_type state_ff, state_in;
   logic [PW-1:0]    wp_ff, wp_in;
   logic [PW-1:0]    rp_ff, rp_in;
   logic [RW-1:0]    room_ff, room_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       byte_ff, byte_in;
   logic             cr_ff, cr_in;
   logic             accept;
   logic             drain_go;
   logic [RW-1:0]    room_clamp;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign wp     = wp_ff;
   assign rp     = rp_ff;

   // clamp the reported room to the FIFO depth
   always_comb begin
      if (32'(req_data.fifo_room) > 32'(UART_FIFO_DEPTH)) begin
         room_clamp = RW'(UART_FIFO_DEPTH);
      end else begin
         room_clamp = RW'(req_data.fifo_room);
      end
   end

   // keep draining while bytes, room and result budget remain
   assign drain_go = !ptr_empty && (room_ff != '0) && (cnt_ff < CNT_W'(RESULT_LIMIT));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.func == FUNC_DRAIN) ? ST_DRAIN : ST_FULL_CHK;
            end
         end
         ST_FULL_CHK: state_in = ptr_full ? ST_FULL_RD : ST_WRITE;
         ST_FULL_RD:  state_in = ST_WRITE;
         ST_WRITE:    state_in = ST_SEND_CHK;
         ST_SEND_CHK: state_in = cr_ff ? ST_FULL_CHK : ST_FINISH;
         ST_DRAIN:    state_in = drain_go ? ST_DRAIN : ST_FINISH;
         ST_FINISH:   state_in = ST_FLUSH;
         ST_FLUSH:    state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      room_in       = room_ff;
      cnt_in        = cnt_ff;
      byte_in       = byte_ff;
      cr_in         = cr_ff;
      ptr_sel       = SEL_RP;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = wp_ff;
      mem_wr_data   = byte_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = rp_ff;
      ctl           = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               byte_in = req_data.data_byte;
               room_in = room_clamp;
               cr_in   = (req_data.func == FUNC_PUSH) && (req_data.data_byte == CHAR_LF);
               cnt_in  = '0;
            end
         end
         ST_FULL_CHK: begin
            ptr_sel = SEL_WP;
         end
         ST_FULL_RD: begin
            // force out the oldest byte
            mem_rd_en     = 1'b1;
            rp_in         = ptr_nxt;
            ctl.rd_fire   = 1'b1;
            ctl.rd_forced = (room_ff == '0);
            if (room_ff != '0) begin
               room_in = room_ff - 1'b1;
            end
         end
         ST_WRITE: begin
            ptr_sel   = SEL_WP;
            mem_wr_en = 1'b1;
            wp_in     = ptr_nxt;
         end
         ST_SEND_CHK: begin
            if (room_ff != '0) begin
               mem_rd_en   = 1'b1;
               rp_in       = ptr_nxt;
               ctl.rd_fire = 1'b1;
               room_in     = room_ff - 1'b1;
            end
            // queue the carriage return after a line feed
            if (cr_ff) begin
               byte_in = CHAR_CR;
               cr_in   = 1'b0;
            end
         end
         ST_DRAIN: begin
            if (drain_go) begin
               mem_rd_en   = 1'b1;
               rp_in       = ptr_nxt;
               ctl.rd_fire = 1'b1;
               room_in     = room_ff - 1'b1;
               cnt_in      = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
         end
         ST_FLUSH: begin
            ctl.flush = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wp_ff    <= '0;
         rp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      room_ff <= room_in;
      cnt_ff  <= cnt_in;
      byte_ff <= byte_in;
      cr_ff   <= cr_in;
   end

endmodule

// File: hdl/urc_rsp_stage.sv
// ----------------------------------------------------------------------------
// urc_rsp_stage
// Result stage: holds each sent byte back one step so the final byte of a
// request can be marked last, and drives the registered result ports.
// ----------------------------------------------------------------------------
module urc_rsp_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  urc_pkg::urc_ctl_type ctl,
   input  logic [7:0]           rd_data,
   input  logic [7:0]           fill,
   output logic                 rsp_strobe,
   output urc_pkg::urc_rsp_type rsp_data
);

   import urc_pkg::*;

   logic        rd_valid_ff;
   logic        rd_forced_ff;
   logic        pend_valid_ff, pend_valid_in;
   urc_rsp_type pend_ff, pend_in;
   logic        rsp_valid_ff, rsp_valid_in;
   urc_rsp_type rsp_ff, rsp_in;

   // track the read in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= ctl.rd_fire;
      end
   end

   always_ff @(posedge clock) begin
      rd_forced_ff <= ctl.rd_forced;
   end

   // release the held byte when a newer one lands or the request ends
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = pend_ff;
      if (rd_valid_ff) begin
         rsp_valid_in      = pend_valid_ff;
         rsp_in.last       = 1'b0;
         pend_valid_in     = 1'b1;
         pend_in.tx_byte   = rd_data;
         pend_in.last      = 1'b0;
         pend_in.forced    = rd_forced_ff;
         pend_in.ring_fill = fill;
      end else if (ctl.flush) begin
         rsp_valid_in  = pend_valid_ff;
         rsp_in.last   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: hdl/uart_tx_ring_crlf_unit.sv
// ----------------------------------------------------------------------------
// uart_tx_ring_crlf_unit
// Transmit ring buffer in front of a UART transmit FIFO, with line feed
// expanded to line feed plus carriage return.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a request on req_data while busy is low. A push request
//   stores data_byte (and a carriage return after a line feed), forcing out
//   the oldest byte when the ring is full and sending one byte per slot of
//   fifo_room. A drain request sends stored bytes while room lasts, at most
//   32 per request.
//   Each byte sent appears on rsp_data for one cycle with rsp_strobe high;
//   the final byte of a request carries last. A request that sends nothing
//   returns no result.
//   Steps: a push goes through full check, write, send check, finish
//   and flush, repeating check, write and send for the carriage return and
//   adding a read step per forced-out byte. A drain sends one byte a cycle
//   through the shared pointer unit and single memory read port. busy falls
//   in the cycle the last result shows, and a new request may be accepted then.
//   Reset clears both pointers (empty ring) and any result in progress. The
//   receiver cannot stall; results must be taken as they appear.
// ----------------------------------------------------------------------------
module uart_tx_ring_crlf_unit #(
   parameter int RING_DEPTH      = urc_pkg::RING_DEPTH_DEF,
   parameter int UART_FIFO_DEPTH = urc_pkg::UART_FIFO_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  urc_pkg::urc_req_type req_data,
   output logic                 rsp_strobe,
   output urc_pkg::urc_rsp_type rsp_data
);

   import urc_pkg::*;

   localparam int PW = $clog2(RING_DEPTH);

   logic [PW-1:0]   wp;
   logic [PW-1:0]   rp;
   urc_ptr_sel_type ptr_sel;
   logic [PW-1:0]   ptr_nxt;
   logic            ptr_full;
   logic            ptr_empty;
   logic [7:0]      fill;
   logic            mem_wr_en;
   logic [PW-1:0]   mem_wr_addr;
   logic [7:0]      mem_wr_data;
   logic            mem_rd_en;
   logic [PW-1:0]   mem_rd_addr;
   logic [7:0]      mem_rd_data;
   urc_ctl_type     ctl;

   // sequence the request
   urc_seq #(
      .RING_DEPTH      (RING_DEPTH),
      .UART_FIFO_DEPTH (UART_FIFO_DEPTH),
      .PW              (PW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .wp          (wp),
      .rp          (rp),
      .ptr_sel     (ptr_sel),
      .ptr_nxt     (ptr_nxt),
      .ptr_full    (ptr_full),
      .ptr_empty   (ptr_empty),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .ctl         (ctl)
   );

   // step and compare the pointers
   urc_ptr_unit #(
      .RING_DEPTH (RING_DEPTH),
      .PW         (PW)
   ) u_ptr (
      .wp    (wp),
      .rp    (rp),
      .sel   (ptr_sel),
      .nxt   (ptr_nxt),
      .full  (ptr_full),
      .empty (ptr_empty),
      .fill  (fill)
   );

   // hold the queued bytes
   urc_ring_mem #(
      .DEPTH (RING_DEPTH),
      .AW    (PW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // mark and drive the results
   urc_rsp_stage u_rsp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .rd_data    (mem_rd_data),
      .fill       (fill),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// File: hdl/urc_checker.sv
// ----------------------------------------------------------------------------
// urc_checker
// Port-level checks on request and result timing, bound to the top level.
// ----------------------------------------------------------------------------
module urc_checker #(
   parameter int RING_DEPTH = urc_pkg::RING_DEPTH_DEF
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_strobe,
   input urc_pkg::urc_rsp_type rsp_data
);

   import urc_pkg::*;

   // an accepted request holds the block busy with no result next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("accepted request did not raise busy or overlapped a result");

   // more results are due while a non-final result shows
   a_nonlast_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |-> busy)
      else $error("non-final result shown while idle");

   // a final result is never directly followed by another
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last) |=> !rsp_strobe)
      else $error("result right after a final result");

   // a forced send leaves the ring one short of full
   a_forced_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.forced) |-> (rsp_data.ring_fill == 8'(RING_DEPTH - 2)))
      else $error("forced send with wrong fill level");

endmodule

bind uart_tx_ring_crlf_unit urc_checker #(.RING_DEPTH(RING_DEPTH)) u_checker (.*);
